/* src/rfr_pkg.sv */
// Shared types and constants for the relay fragment reassembler.
`default_nettype none
package rfr_pkg;

  // Geometry of a reassembled message and of a fragment header
  localparam int unsigned MSG_BYTES = 8;
  localparam int unsigned HDR_BYTES = 3;

  // Request and status codes
  localparam logic REQ_FRAG = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  // Timeout register value after reset
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef logic [7:0] byte_t;

  // One accepted input item
  typedef struct packed {
    logic                         req_type;
    logic [3:0]                   frame_len;
    byte_t [MSG_BYTES-1:0]        bytes;
  } item_t;

  // Reassembly state
  typedef struct packed {
    logic                         id_latched;
    logic [15:0]                  held_id;
    logic [7:0]                   held_total;
    logic [3:0]                   fill_count;
    byte_t [MSG_BYTES-1:0]        data_store;
    logic [15:0]                  tick_count;
  } state_t;

  // One result item
  typedef struct packed {
    logic                         status;
    logic [15:0]                  msg_id;
    logic [7:0]                   msg_len;
    byte_t [MSG_BYTES-1:0]        data;
  } result_t;

endpackage
`default_nettype wire

/* src/rfr_step.sv */
// Next-state and result logic for one item against the reassembly state.
`default_nettype none
module rfr_step
  import rfr_pkg::*;
(
  input  wire state_t      cur,
  input  wire item_t       item,
  input  wire logic [15:0] timeout_ticks,
  output state_t           nxt,
  output logic             emit,
  output result_t          res
);

  always_comb begin
    logic [3:0]  len;
    logic [2:0]  payload;
    logic [15:0] frag_id;
    logic [7:0]  eff_total;
    logic [15:0] tick_inc;
    logic [3:0]  off;
    logic [4:0]  fill_sum;
    logic [3:0]  new_fill;
    logic        fits;
    state_t      w;

    w    = cur;
    emit = 1'b0;
    res  = '0;
    off  = '0;

    // Clamp the frame length and split off the header
    len      = (item.frame_len > 4'(MSG_BYTES)) ? 4'(MSG_BYTES) : item.frame_len;
    payload  = 3'(len - 4'(HDR_BYTES));
    frag_id  = {item.bytes[0], item.bytes[1]};
    fill_sum = {1'b0, cur.fill_count} + 5'(payload);
    fits     = fill_sum <= 5'(MSG_BYTES);
    new_fill = fill_sum[3:0];
    eff_total = cur.id_latched ? cur.held_total : item.bytes[2];
    tick_inc  = (cur.tick_count == 16'hFFFF) ? cur.tick_count : cur.tick_count + 16'd1;

    case (item.req_type)
      REQ_TICK: begin
        // Count the tick and abandon the message on timeout
        w.tick_count = tick_inc;
        if (tick_inc >= timeout_ticks) begin
          emit       = 1'b1;
          res.status = STATUS_TIMEOUT;
        end
      end
      REQ_FRAG: begin
        if (len >= 4'(HDR_BYTES) && (!cur.id_latched || frag_id == cur.held_id)) begin
          // Latch the header on the first fragment
          if (!cur.id_latched) begin
            w.id_latched = 1'b1;
            w.held_id    = frag_id;
            w.held_total = item.bytes[2];
            w.fill_count = '0;
          end
          // Place payload bytes at the fill offset while the message fits
          if (fits) begin
            for (int j = 0; j < MSG_BYTES; j++) begin
              off = 4'(j) - cur.fill_count;
              if (4'(j) >= cur.fill_count && off < {1'b0, payload}) begin
                w.data_store[j] = item.bytes[3'(off[2:0] + 3'(HDR_BYTES))];
              end
            end
            w.fill_count = new_fill;
          end
          if ({4'b0, w.fill_count} >= eff_total) begin
            emit       = 1'b1;
            res.status = STATUS_DONE;
          end
        end
      end
      default: begin
        w = cur;
      end
    endcase

    res.msg_id  = w.held_id;
    res.msg_len = w.held_total;
    res.data    = w.data_store;

    // Drop everything once a result leaves
    nxt = emit ? state_t'('0) : w;
  end

endmodule
`default_nettype wire

/* src/relay_fragment_reassembler_unit.sv */
// Top level of the relay fragment reassembler.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, req_type .. byte7   | in
//  result  | out_valid, out_stall, status .. data7   | out
//  config  | cfg_wr_en, cfg_wr_data (timeout_ticks)  | in
//
// One item per cycle while the result is not stalled: an item is held in the
// input register and its result, if any, is registered into the result register.
// The reassembly state is updated in the same single pass, so consecutive
// items see each other's effect with no gap.
// Reset clears the state, the valid flags and sets the timeout to 1000.
// A stalled result holds; the input register still takes one more item.
`default_nettype none
module relay_fragment_reassembler_unit
  import rfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [3:0]  frame_len,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  input  wire logic [7:0]  byte2,
  input  wire logic [7:0]  byte3,
  input  wire logic [7:0]  byte4,
  input  wire logic [7:0]  byte5,
  input  wire logic [7:0]  byte6,
  input  wire logic [7:0]  byte7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [15:0]      msg_id,
  output logic [7:0]       msg_len,
  output logic [7:0]       data0,
  output logic [7:0]       data1,
  output logic [7:0]       data2,
  output logic [7:0]       data3,
  output logic [7:0]       data4,
  output logic [7:0]       data5,
  output logic [7:0]       data6,
  output logic [7:0]       data7
);

  logic [15:0] timeout_ticks;
  logic        iv;
  item_t       item;
  state_t      st;
  state_t      st_next;
  logic        emit;
  result_t     res_next;
  result_t     res;
  logic        advance;
  logic        in_xfer;

  // Process the held item only when the result register is free
  assign advance  = iv && (!out_valid || !out_stall);
  assign in_stall = iv && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_xfer) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= '{req_type: req_type, frame_len: frame_len,
                bytes: {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0}};
    end
  end

  rfr_step u_step (
    .cur           (st),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .nxt           (st_next),
    .emit          (emit),
    .res           (res_next)
  );

  // Reassembly state: advance once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_next;
    end
  end

  assign status  = res.status;
  assign msg_id  = res.msg_id;
  assign msg_len = res.msg_len;
  assign data0   = res.data[0];
  assign data1   = res.data[1];
  assign data2   = res.data[2];
  assign data3   = res.data[3];
  assign data4   = res.data[4];
  assign data5   = res.data[5];
  assign data6   = res.data[6];
  assign data7   = res.data[7];

`ifndef ASSERT_OFF
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("result not presented after emit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    st.fill_count <= 4'(MSG_BYTES))
    else $error("fill count beyond message size");

  a_unlatched_clean: assert property (@(posedge clk) disable iff (rst)
    !st.id_latched |-> (st.fill_count == 4'd0 && st.held_id == 16'd0))
    else $error("state left over without a latched id");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (iv && out_valid && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

/* dv/rfr_frame_checker.sv */
// Checker for the relay fragment reassembler: predicts frames and compares results.
module rfr_frame_checker
  import rfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        req_type,
  input  wire logic [3:0]  frame_len,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  input  wire logic [7:0]  byte2,
  input  wire logic [7:0]  byte3,
  input  wire logic [7:0]  byte4,
  input  wire logic [7:0]  byte5,
  input  wire logic [7:0]  byte6,
  input  wire logic [7:0]  byte7,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        status,
  input  wire logic [15:0] msg_id,
  input  wire logic [7:0]  msg_len,
  input  wire logic [7:0]  data0,
  input  wire logic [7:0]  data1,
  input  wire logic [7:0]  data2,
  input  wire logic [7:0]  data3,
  input  wire logic [7:0]  data4,
  input  wire logic [7:0]  data5,
  input  wire logic [7:0]  data6,
  input  wire logic [7:0]  data7,
  output int               mismatch_count,
  output int               frames_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  state_t      asm_st;
  logic [15:0] tick_limit;
  result_t     frames_due[$];

  initial begin
    mismatch_count = 0;
    frames_owed    = 0;
  end

  // Queue the frame held so far, then drop all reassembly state
  task automatic post_frame(input logic code);
    result_t r;
    r.status  = code;
    r.msg_id  = asm_st.held_id;
    r.msg_len = asm_st.held_total;
    r.data    = asm_st.data_store;
    frames_due.push_back(r);
    asm_st = '0;
  endtask

  // Advance the reassembly state by one accepted transfer
  task automatic reassemble(input item_t it);
    logic [3:0]  len;
    logic [15:0] frag_id;
    int          payload;
    if (it.req_type == REQ_TICK) begin
      if (asm_st.tick_count != 16'hFFFF) asm_st.tick_count++;
      if (asm_st.tick_count >= tick_limit) post_frame(STATUS_TIMEOUT);
      return;
    end
    len = (it.frame_len > MSG_BYTES) ? 4'(MSG_BYTES) : it.frame_len;
    if (len < HDR_BYTES) return;
    frag_id = {it.bytes[0], it.bytes[1]};
    payload = int'(len) - HDR_BYTES;
    if (!asm_st.id_latched) begin
      asm_st.id_latched = 1'b1;
      asm_st.held_id    = frag_id;
      asm_st.held_total = it.bytes[2];
      asm_st.fill_count = '0;
    end else if (frag_id != asm_st.held_id) begin
      return;
    end
    // Place payload only while the whole fragment still fits
    if (int'(asm_st.fill_count) + payload <= MSG_BYTES) begin
      for (int i = 0; i < payload; i++)
        asm_st.data_store[(int'(asm_st.fill_count) + i) % MSG_BYTES] = it.bytes[HDR_BYTES + i];
      asm_st.fill_count = 4'(int'(asm_st.fill_count) + payload);
    end
    if (asm_st.fill_count >= asm_st.held_total) post_frame(STATUS_DONE);
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    item_t   it;
    if (rst) begin
      asm_st     = '0;
      tick_limit = TIMEOUT_RESET;
      frames_due.delete();
    end else begin
      // Compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        got.status  = status;
        got.msg_id  = msg_id;
        got.msg_len = msg_len;
        got.data    = {data7, data6, data5, data4, data3, data2, data1, data0};
        if (frames_due.size() == 0) begin
          $error("unexpected result: status %0d msg_id %04h msg_len %0d",
                 status, msg_id, msg_len);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.msg_id !== want.msg_id) begin
            $error("msg_id expected %04h got %04h", want.msg_id, got.msg_id);
            mismatch_count++;
          end
          if (got.msg_len !== want.msg_len) begin
            $error("msg_len expected %0d got %0d", want.msg_len, got.msg_len);
            mismatch_count++;
          end
          for (int b = 0; b < MSG_BYTES; b++) begin
            if (got.data[b] !== want.data[b]) begin
              $error("data%0d expected %02h got %02h", b, want.data[b], got.data[b]);
              mismatch_count++;
            end
          end
        end
      end
      // Track the timeout register
      if (cfg_wr_en) tick_limit = cfg_wr_data;
      // Predict from an accepted input transfer
      if (in_valid && !in_stall) begin
        it.req_type  = req_type;
        it.frame_len = frame_len;
        it.bytes     = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
        reassemble(it);
      end
    end
    frames_owed = frames_due.size();
  end

endmodule

/* dv/relay_fragment_reassembler_unit_tb.sv */
// Testbench top for the relay fragment reassembler: stimulus, idling and verdict.
module relay_fragment_reassembler_unit_tb;
  import rfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_FRAG;
  logic [3:0]  frame_len = '0;
  logic [7:0]  byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0;
  logic [7:0]  byte4 = '0, byte5 = '0, byte6 = '0, byte7 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [15:0] msg_id;
  logic [7:0]  msg_len;
  logic [7:0]  data0, data1, data2, data3, data4, data5, data6, data7;

  int          mismatch_count;
  int          frames_owed;
  int          send_gap_pct = 8;
  int          recv_stall_pct = 70;
  int          items_sent = 0;
  logic [15:0] timeout_now = TIMEOUT_RESET;

  relay_fragment_reassembler_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .frame_len(frame_len),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .msg_id(msg_id), .msg_len(msg_len),
    .data0(data0), .data1(data1), .data2(data2), .data3(data3),
    .data4(data4), .data5(data5), .data6(data6), .data7(data7)
  );

  rfr_frame_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .frame_len(frame_len),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .msg_id(msg_id), .msg_len(msg_len),
    .data0(data0), .data1(data1), .data2(data2), .data3(data3),
    .data4(data4), .data5(data5), .data6(data6), .data7(data7),
    .mismatch_count(mismatch_count), .frames_owed(frames_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Present one transfer and hold it until accepted
  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    req_type  = it.req_type;
    frame_len = it.frame_len;
    byte0 = it.bytes[0];
    byte1 = it.bytes[1];
    byte2 = it.bytes[2];
    byte3 = it.bytes[3];
    byte4 = it.bytes[4];
    byte5 = it.bytes[5];
    byte6 = it.bytes[6];
    byte7 = it.bytes[7];
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.req_type == REQ_TICK || it.frame_len >= HDR_BYTES) items_sent++;
  endtask

  // Fragment with the given header; pad below zero gives random payload
  task automatic send_frag(input logic [15:0] id, input logic [7:0] total,
                           input logic [3:0] len, input int pad);
    item_t it;
    it.req_type  = REQ_FRAG;
    it.frame_len = len;
    for (int b = 0; b < MSG_BYTES; b++)
      it.bytes[b] = (pad < 0) ? 8'($urandom_range(0, 255)) : 8'(pad);
    it.bytes[0] = id[15:8];
    it.bytes[1] = id[7:0];
    it.bytes[2] = total;
    send_item(it);
  endtask

  // Timer tick with junk in the unused fields
  task automatic send_tick();
    item_t it;
    it.req_type  = REQ_TICK;
    it.frame_len = 4'($urandom_range(0, 15));
    for (int b = 0; b < MSG_BYTES; b++) it.bytes[b] = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Drain the block, then write the timeout register
  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (frames_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    timeout_now = value;
  endtask

  // One message split into fragments, with noise between them
  task automatic send_random_message();
    logic [15:0] id;
    logic [3:0]  len;
    int          total;
    int          filled;
    int          chunk;
    int          frags;
    if ($urandom_range(0, 7) == 0)
      id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else
      id = 16'($urandom_range(0, 65535));
    total = $urandom_range(1, MSG_BYTES);
    case ($urandom_range(0, 9))
      0: total = 0;
      // Oversized totals only end by timeout, so keep them to short timeouts
      1: if (timeout_now <= 64) total = $urandom_range(MSG_BYTES + 1, 255);
      default: ;
    endcase
    filled = 0;
    frags  = 0;
    do begin
      chunk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      if (total <= MSG_BYTES && chunk > total - filled) chunk = total - filled;
      len = 4'(HDR_BYTES + chunk);
      if (chunk == 5 && $urandom_range(0, 1)) len = 4'($urandom_range(9, 15));
      send_frag(id, 8'(total), len, -1);
      filled += chunk;
      frags++;
      if (filled < total && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: send_tick();
          1: send_frag(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       4'($urandom_range(0, 2)), -1);
          2: send_frag(~id, 8'd0, 4'($urandom_range(3, 15)), -1);
          default: begin
            // Payload that no longer fits is discarded
            if (filled > 3) send_frag(id, 8'(total), 4'(MSG_BYTES), -1);
            else send_tick();
          end
        endcase
      end
    end while (filled < total && frags < 10);
    if (timeout_now <= 64 && (total > MSG_BYTES || $urandom_range(0, 3) == 0))
      repeat ((timeout_now == 0) ? 1 : int'(timeout_now)) send_tick();
  endtask

  initial begin
    logic [15:0] phase_limit [6];
    int          start;
    phase_limit = '{16'd1, 16'd20, 16'd0, 16'($urandom_range(2, 60)),
                    TIMEOUT_RESET, 16'hFFFF};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: idle tick and short frames under the reset timeout
    send_tick();
    send_frag(16'hABCD, 8'd5, 4'd0, -1);
    send_frag(16'hABCD, 8'd5, 4'd1, -1);
    send_frag(16'hABCD, 8'd5, 4'd2, -1);
    // Zero total completes at once
    send_frag(16'hFFFF, 8'd0, 4'd3, 8'hFF);
    // Two-fragment message with a foreign id and an overflowing overlong frame
    send_frag(16'h0000, 8'd8, 4'd8, 8'h00);
    send_frag(16'h0001, 8'd8, 4'd8, -1);
    send_frag(16'h0000, 8'd8, 4'd15, -1);
    send_frag(16'h0000, 8'd8, 4'd6, 8'hFF);
    // Total above eight: fill to the end, then overflow
    send_frag(16'h5A5A, 8'hFF, 4'd9, -1);
    send_frag(16'h5A5A, 8'hFF, 4'd6, -1);
    send_frag(16'h5A5A, 8'hFF, 4'd4, -1);
    // Zero timeout: partial contents, then an empty timeout
    write_timeout(16'd0);
    send_tick();
    send_tick();
    // Header-only fragment, ticks below the limit, then completion
    write_timeout(16'd3);
    send_frag(16'h8001, 8'd2, 4'd3, -1);
    send_tick();
    send_tick();
    send_frag(16'h8001, 8'd2, 4'd5, -1);
    repeat (3) send_tick();
    send_frag(16'h7E7E, 8'd1, 4'd12, -1);

    // Random phases over several timeouts and idling modes
    for (int p = 0; p < 6; p++) begin
      send_gap_pct   = (p < 2) ? 8 : (p < 4) ? 70 : 0;
      recv_stall_pct = (p < 2) ? 70 : (p < 4) ? 8 : 0;
      write_timeout(phase_limit[p]);
      start = items_sent;
      while (items_sent - start < 65) send_random_message();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (frames_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Abandon a hung run
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* relay_fragment_reassembler_unit.f */
src/rfr_pkg.sv
src/rfr_step.sv
src/relay_fragment_reassembler_unit.sv
dv/rfr_frame_checker.sv
dv/relay_fragment_reassembler_unit_tb.sv
